>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define AMOU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define AMOU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/amou_pkg.sv
// Types and constants shared by the atomic memory operation unit.
package amou_pkg;

    localparam int XLEN      = 64;
    localparam int HALF      = 32;
    localparam int MODE_W    = 4;
    localparam int STATUS_W  = 2;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [XLEN-1:0]     word_t;

    // Operation codes.
    localparam mode_t MODE_ADD  = 4'd0;
    localparam mode_t MODE_SWAP = 4'd1;
    localparam mode_t MODE_LR   = 4'd2;
    localparam mode_t MODE_SC   = 4'd3;
    localparam mode_t MODE_XOR  = 4'd4;
    localparam mode_t MODE_OR   = 4'd5;
    localparam mode_t MODE_AND  = 4'd6;
    localparam mode_t MODE_MIN  = 4'd7;
    localparam mode_t MODE_MAX  = 4'd8;
    localparam mode_t MODE_MINU = 4'd9;
    localparam mode_t MODE_MAXU = 4'd10;

    // Status codes.
    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_MISALIGNED = 2'd1;
    localparam status_t ST_ILLEGAL    = 2'd2;

    // One result beat.
    typedef struct packed {
        status_t status;
        logic    rd_write;
        word_t   rd_value;
        logic    store_enable;
        word_t   store_value;
    } result_t;

    // Update of the reservation register requested by one operation.
    typedef struct packed {
        logic  set;
        logic  clr;
        word_t addr;
    } resv_upd_t;

    // Sign-extend the low half of a doubleword.
    function automatic word_t sext_half(input word_t v);
        return {{(XLEN-HALF){v[HALF-1]}}, v[HALF-1:0]};
    endfunction

endpackage

>>> rtl/atomic_memory_operation_unit_top.sv
// Top level of the atomic memory operation unit.
// The unit executes one RV64A atomic operation per beat and accepts a new beat in every
// cycle unless both registers are full and the result is stalled. An accepted beat is
// held in the input register, executed as it moves into the result register and
// presented from there. Both registers advance only when the stage behind them is free,
// so a stalled result holds while one more beat can still be taken into the input
// register. The single reservation is read and updated as a beat moves from the input
// register into the result register, which keeps load-reserved and store-conditional
// pairs in program order.
module atomic_memory_operation_unit_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  amou_pkg::mode_t   mode,
    input  logic              is_double,
    input  amou_pkg::word_t   address,
    input  amou_pkg::word_t   operand_value,
    input  amou_pkg::word_t   memory_value,
    output logic              out_valid,
    input  logic              out_ready,
    output amou_pkg::status_t status,
    output logic              rd_write,
    output amou_pkg::word_t   rd_value,
    output logic              store_enable,
    output amou_pkg::word_t   store_value
);
    import amou_pkg::*;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    mode_t     mode_reg;
    logic      is_double_reg;
    word_t     address_reg;
    word_t     operand_reg;
    word_t     memory_reg;
    logic      s2_valid_reg;
    logic      s2_valid_next;
    result_t   result_reg;
    result_t   exec_result;
    resv_upd_t exec_upd;
    logic      resv_valid;
    word_t     resv_address;
    logic      s2_load;
    logic      s1_load;

    // Stage handshakes.
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !s2_valid_reg || out_ready;
    assign s1_load  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_load || (s1_valid_reg && !s2_load);
        s2_valid_next = s2_load || (s2_valid_reg && !out_ready);
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            mode_reg      <= mode;
            is_double_reg <= is_double;
            address_reg   <= address;
            operand_reg   <= operand_value;
            memory_reg    <= memory_value;
        end
    end

    amou_exec u_exec (
        .mode          (mode_reg),
        .is_double     (is_double_reg),
        .address       (address_reg),
        .operand_value (operand_reg),
        .memory_value  (memory_reg),
        .resv_valid    (resv_valid),
        .resv_address  (resv_address),
        .result        (exec_result),
        .upd           (exec_upd)
    );

    amou_resv u_resv (
        .clk          (clk),
        .rst_n        (rst_n),
        .upd_en       (s2_load),
        .upd          (exec_upd),
        .resv_valid   (resv_valid),
        .resv_address (resv_address)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            result_reg <= exec_result;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign status       = result_reg.status;
    assign rd_write     = result_reg.rd_write;
    assign rd_value     = result_reg.rd_value;
    assign store_enable = result_reg.store_enable;
    assign store_value  = result_reg.store_value;

endmodule

>>> rtl/amou_exec.sv
// Combinational execution of one atomic operation.
module amou_exec (
    input  amou_pkg::mode_t     mode,
    input  logic                is_double,
    input  amou_pkg::word_t     address,
    input  amou_pkg::word_t     operand_value,
    input  amou_pkg::word_t     memory_value,
    input  logic                resv_valid,
    input  amou_pkg::word_t     resv_address,
    output amou_pkg::result_t   result,
    output amou_pkg::resv_upd_t upd
);
    import amou_pkg::*;

    logic  illegal;
    logic  misaligned;
    word_t a;
    word_t b;
    logic  slt;
    logic  ult;
    logic  hit;
    word_t res;

    // Operand preparation and compares.
    always_comb
    begin
        illegal    = (mode > MODE_MAXU);
        misaligned = is_double ? (address[2:0] != 3'd0) : (address[1:0] != 2'd0);
        a          = is_double ? memory_value : sext_half(memory_value);
        b          = is_double ? operand_value : sext_half(operand_value);
        // Word operands are sign-extended, so one 64-bit signed compare serves both sizes.
        slt        = ($signed(a) < $signed(b));
        ult        = is_double ? (a < b) : (a[HALF-1:0] < b[HALF-1:0]);
        hit        = resv_valid && (resv_address == address);
    end

    // Read-modify-write value.
    always_comb
    begin
        unique case (mode)
            MODE_ADD:  res = a + b;
            MODE_XOR:  res = a ^ b;
            MODE_OR:   res = a | b;
            MODE_AND:  res = a & b;
            MODE_MIN:  res = slt ? a : b;
            MODE_MAX:  res = slt ? b : a;
            MODE_MINU: res = ult ? a : b;
            MODE_MAXU: res = ult ? b : a;
            default:   res = b;
        endcase
    end

    // Result and reservation update.
    always_comb
    begin
        result.status       = ST_OK;
        result.rd_write     = 1'b0;
        result.rd_value     = '0;
        result.store_enable = 1'b0;
        result.store_value  = '0;
        upd.set             = 1'b0;
        upd.clr             = 1'b0;
        upd.addr            = address;
        priority if (illegal)
        begin
            result.status = ST_ILLEGAL;
        end
        else if (misaligned)
        begin
            result.status = ST_MISALIGNED;
        end
        else if (mode == MODE_LR)
        begin
            result.rd_write = 1'b1;
            result.rd_value = a;
            upd.set         = 1'b1;
        end
        else if (mode == MODE_SC)
        begin
            upd.clr             = 1'b1;
            result.rd_write     = 1'b1;
            result.rd_value     = hit ? '0 : word_t'(1);
            result.store_enable = hit;
            if (hit)
            begin
                result.store_value = is_double ? operand_value
                                               : {{(XLEN-HALF){1'b0}}, operand_value[HALF-1:0]};
            end
        end
        else
        begin
            result.rd_write     = 1'b1;
            result.rd_value     = a;
            result.store_enable = 1'b1;
            result.store_value  = is_double ? res : {{(XLEN-HALF){1'b0}}, res[HALF-1:0]};
        end
    end

endmodule

>>> rtl/amou_resv.sv
// Single load-reserved reservation register.
module amou_resv (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                upd_en,
    input  amou_pkg::resv_upd_t upd,
    output logic                resv_valid,
    output amou_pkg::word_t     resv_address
);
    import amou_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    word_t addr_reg;
    word_t addr_next;

    // A load-reserved sets the reservation; a store-conditional clears it.
    always_comb
    begin
        valid_next = valid_reg;
        addr_next  = addr_reg;
        if (upd_en)
        begin
            if (upd.set)
            begin
                valid_next = 1'b1;
                addr_next  = upd.addr;
            end
            else if (upd.clr)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            addr_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            addr_reg  <= addr_next;
        end
    end

    assign resv_valid   = valid_reg;
    assign resv_address = addr_reg;

endmodule

>>> rtl/amou_checker.sv
// Port-level assertions for the atomic memory operation unit, bound to its top level.
`include "assert_macros.svh"

module amou_port_assertions (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input amou_pkg::status_t status,
    input logic              rd_write,
    input amou_pkg::word_t   rd_value,
    input logic              store_enable,
    input amou_pkg::word_t   store_value
);
    import amou_pkg::*;

    // A stalled result beat stays and keeps its payload.
    `AMOU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(rd_value) && $stable(store_value),
        "result beat changed while stalled")

    // An aborted operation writes nothing and returns zeros.
    `AMOU_ASSERT_SAME(a_abort_quiet, clk, rst_n, out_valid && (status != ST_OK),
        !rd_write && !store_enable && (rd_value == '0) && (store_value == '0),
        "aborted operation has side effects")

    // Every completed operation writes the destination register.
    `AMOU_ASSERT_SAME(a_ok_writes_rd, clk, rst_n, out_valid && (status == ST_OK),
        rd_write, "completed operation did not write rd")

    // Without a store the store value is zero.
    `AMOU_ASSERT_SAME(a_no_store_zero, clk, rst_n, out_valid && !store_enable,
        store_value == '0, "store value set without a store")

endmodule

bind atomic_memory_operation_unit_top amou_port_assertions u_amou_port_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .rd_write     (rd_write),
    .rd_value     (rd_value),
    .store_enable (store_enable),
    .store_value  (store_value)
);

>>> sim/amou_checker.sv
// Checker for the atomic memory operation unit: predicts every result beat and compares it.
module amou_checker
    import amou_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_ready,
    input  mode_t   mode,
    input  logic    is_double,
    input  word_t   address,
    input  word_t   operand_value,
    input  word_t   memory_value,
    input  logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    input  logic    rd_write,
    input  word_t   rd_value,
    input  logic    store_enable,
    input  word_t   store_value,
    output int      fail_count,
    output int      pending,
    output int      checked,
    output int      sc_success
);

    localparam word_t WORD_MASK  = 64'h3;
    localparam word_t DWORD_MASK = 64'h7;

    // Shadow copy of the single reservation.
    logic    resv_valid;
    word_t   resv_addr;

    // Results predicted for accepted operations, oldest first.
    result_t expected_q[$];
    result_t want;

    int      n_fail    = 0;
    int      n_checked = 0;
    int      n_sc_hit  = 0;

    // Sign-extend the low 32 bits of a value to the full register width.
    function automatic word_t widen_word(input word_t v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    // Work out the result of one operation and update the shadow reservation.
    function automatic result_t predict_amo(input mode_t m, input logic dbl, input word_t addr,
                                            input word_t opv, input word_t memv);
        result_t r;
        word_t   a;
        word_t   b;
        word_t   res;
        logic    hit;
        r   = '0;
        res = '0;

        // An illegal code wins over a misaligned address.
        if (m > MODE_MAXU)
        begin
            r.status = ST_ILLEGAL;
            return r;
        end
        if ((addr & (dbl ? DWORD_MASK : WORD_MASK)) != '0)
        begin
            r.status = ST_MISALIGNED;
            return r;
        end

        a = dbl ? memv : widen_word(memv);
        b = dbl ? opv : widen_word(opv);

        case (m)
            MODE_LR:
            begin
                r.rd_write = 1'b1;
                r.rd_value = a;
                resv_valid = 1'b1;
                resv_addr  = addr;
                return r;
            end
            MODE_SC:
            begin
                hit        = resv_valid && (resv_addr == addr);
                resv_valid = 1'b0;
                r.rd_write = 1'b1;
                if (hit)
                begin
                    r.rd_value     = '0;
                    r.store_enable = 1'b1;
                    r.store_value  = dbl ? opv : {32'h0, opv[31:0]};
                    n_sc_hit++;
                end
                else
                begin
                    r.rd_value = 64'd1;
                end
                return r;
            end
            MODE_ADD:  res = a + b;
            MODE_SWAP: res = b;
            MODE_XOR:  res = a ^ b;
            MODE_OR:   res = a | b;
            MODE_AND:  res = a & b;
            MODE_MIN:  res = ($signed(a) < $signed(b)) ? a : b;
            MODE_MAX:  res = ($signed(a) < $signed(b)) ? b : a;
            MODE_MINU:
            begin
                if (dbl)
                    res = (a < b) ? a : b;
                else
                    res = (a[31:0] < b[31:0]) ? a : b;
            end
            default:
            begin
                if (dbl)
                    res = (a < b) ? b : a;
                else
                    res = (a[31:0] < b[31:0]) ? b : a;
            end
        endcase

        r.rd_write     = 1'b1;
        r.rd_value     = a;
        r.store_enable = 1'b1;
        r.store_value  = dbl ? res : {32'h0, res[31:0]};
        return r;
    endfunction

    // Report one field that differs from its prediction.
    function automatic void check_field(input string name, input word_t exp_val,
                                        input word_t got_val);
        if (exp_val !== got_val)
        begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            n_fail++;
        end
    endfunction

    // Result beats are matched before the new operation beat is predicted, so that a
    // beat with nothing waiting can never pair with an operation taken in the same cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            resv_valid = 1'b0;
            resv_addr  = '0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat arrived with no operation pending");
                    n_fail++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("status", word_t'(want.status), word_t'(status));
                    check_field("rd_write", word_t'(want.rd_write), word_t'(rd_write));
                    check_field("rd_value", want.rd_value, rd_value);
                    check_field("store_enable", word_t'(want.store_enable),
                                word_t'(store_enable));
                    check_field("store_value", want.store_value, store_value);
                    n_checked++;
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_amo(mode, is_double, address, operand_value,
                                                 memory_value));
            pending <= expected_q.size();
        end
        fail_count <= n_fail;
        checked    <= n_checked;
        sc_success <= n_sc_hit;
    end

endmodule

>>> sim/tb_top.sv
// Testbench top for the atomic memory operation unit: clock, reset, stimulus and verdict.
module tb_top;
    import amou_pkg::*;

    localparam int    TOTAL_ITEMS        = 1650;
    localparam int    CYCLE_LIMIT        = 500000;
    localparam int    MAX_GAP            = 19;
    localparam int    HOLD_CYCLES        = 150;
    localparam int    HOLD_AT_FIRST      = 300;
    localparam int    HOLD_AT_SECOND     = 1200;
    localparam int    PHASE_ITEMS        = 150;
    localparam int    DRAIN_CYCLES       = 20;
    localparam int    RESET_CYCLES       = 5;
    localparam mode_t MODE_ILLEGAL_FIRST = 4'd11;
    localparam mode_t MODE_ILLEGAL_LAST  = 4'd15;
    localparam word_t WORD_MASK          = 64'h3;
    localparam word_t DWORD_MASK         = 64'h7;

    logic    clk           = 1'b0;
    logic    rst_n         = 1'b0;
    logic    in_valid      = 1'b0;
    mode_t   mode          = MODE_ADD;
    logic    is_double     = 1'b0;
    word_t   address       = '0;
    word_t   operand_value = '0;
    word_t   memory_value  = '0;
    logic    out_ready     = 1'b0;

    logic    in_ready;
    logic    out_valid;
    status_t status;
    logic    rd_write;
    word_t   rd_value;
    logic    store_enable;
    word_t   store_value;

    int      fail_count;
    int      pending;
    int      checked;
    int      sc_success;

    int      sent_count     = 0;
    int      cycle_count    = 0;
    int      directed_items = 0;
    int      lrsc_sequences = 0;
    logic    no_idle        = 1'b0;

    atomic_memory_operation_unit_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .is_double     (is_double),
        .address       (address),
        .operand_value (operand_value),
        .memory_value  (memory_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .rd_write      (rd_write),
        .rd_value      (rd_value),
        .store_enable  (store_enable),
        .store_value   (store_value)
    );

    amou_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .is_double     (is_double),
        .address       (address),
        .operand_value (operand_value),
        .memory_value  (memory_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .rd_write      (rd_write),
        .rd_value      (rd_value),
        .store_enable  (store_enable),
        .store_value   (store_value),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked),
        .sc_success    (sc_success)
    );

    // Free-running clock, period 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    // Operand or memory value, biased toward sign and carry boundaries.
    function automatic word_t pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 64'h7FFF_FFFF_FFFF_FFFF;
            3:       return 64'h8000_0000_0000_0000;
            4:       return {$urandom, 32'h7FFF_FFFF};
            5:       return {$urandom, 32'h8000_0000};
            default: return rand_word();
        endcase
    endfunction

    function automatic word_t aligned_addr(input logic dbl);
        return rand_word() & ~(dbl ? DWORD_MASK : WORD_MASK);
    endfunction

    function automatic mode_t legal_mode();
        return mode_t'($urandom_range(MODE_ADD, MODE_MAXU));
    endfunction

    // Offer one operation beat after a random gap and wait until it is taken.
    task automatic send_amo(input mode_t m, input logic dbl, input word_t addr,
                            input word_t opv, input word_t memv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode          <= m;
        is_double     <= dbl;
        address       <= addr;
        operand_value <= opv;
        memory_value  <= memv;
        in_valid      <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    // Result side: random stalls per beat, and two long hold-offs that back the unit up.
    initial
    begin : result_sink
        int gap;
        int received;
        received = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (received == HOLD_AT_FIRST || received == HOLD_AT_SECOND)
                gap = HOLD_CYCLES;
            else if (no_idle)
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            received++;
        end
    end

    initial
    begin : stimulus
        word_t addr;
        word_t sc_addr;
        logic  dbl;
        logic  op_dbl;
        int    kind;
        int    steps;
        int    next_phase;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reservation rules first, then every operation at its extremes.
        send_amo(MODE_SC, 1'b1, 64'h0, 64'h1234, 64'h0);
        send_amo(MODE_LR, 1'b1, 64'hFFFF_FFFF_FFFF_FFF8, 64'h0, 64'h8000_0000_0000_0000);
        send_amo(MODE_ILLEGAL_FIRST, 1'b1, 64'hFFFF_FFFF_FFFF_FFFB, '1, '1);
        send_amo(MODE_SC, 1'b0, 64'hFFFF_FFFF_FFFF_FFF9, '1, '1);
        send_amo(MODE_SC, 1'b1, 64'hFFFF_FFFF_FFFF_FFF8, '1, 64'h5);
        send_amo(MODE_SC, 1'b1, 64'hFFFF_FFFF_FFFF_FFF8, '1, 64'h5);
        send_amo(MODE_LR, 1'b0, 64'h4, 64'h0, 64'h0000_0000_8000_0000);
        send_amo(MODE_SC, 1'b0, 64'h8, 64'hFFFF_FFFF_0000_0001, 64'h0);
        send_amo(MODE_ADD, 1'b0, 64'h0, 64'h1, 64'hDEAD_BEEF_FFFF_FFFF);
        send_amo(MODE_ADD, 1'b1, 64'h8, '1, '1);
        send_amo(MODE_SWAP, 1'b0, 64'hC, 64'hFFFF_FFFF_1234_5678, 64'h0);
        send_amo(MODE_XOR, 1'b1, 64'h10, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_amo(MODE_OR, 1'b0, 64'h14, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF_0000_0001);
        send_amo(MODE_AND, 1'b1, 64'h18, '1, 64'h8000_0000_0000_0001);
        send_amo(MODE_MIN, 1'b0, 64'h1C, 64'h0000_0000_8000_0000, 64'h0000_0000_7FFF_FFFF);
        send_amo(MODE_MAX, 1'b1, 64'h20, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        send_amo(MODE_MINU, 1'b0, 64'h24, 64'h0000_0000_8000_0000, 64'h1);
        send_amo(MODE_MAXU, 1'b0, 64'h28, 64'h0000_0000_FFFF_FFFF, 64'h0);
        send_amo(MODE_MINU, 1'b1, 64'h30, '1, 64'h0);
        send_amo(MODE_MAXU, 1'b1, 64'h38, 64'h0, '1);
        send_amo(MODE_MIN, 1'b1, 64'h40, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_amo(MODE_ILLEGAL_LAST, 1'b0, 64'h44, '1, '1);
        send_amo(MODE_ADD, 1'b1, 64'h4, 64'h1, 64'h1);
        send_amo(MODE_MAXU, 1'b0, 64'h2, 64'h1, 64'h1);
        directed_items = sent_count;

        // Random: mostly reservation sequences and aligned operations, some noise.
        next_phase = sent_count;
        while (sent_count < TOTAL_ITEMS)
        begin
            // Each phase either idles at random or runs both sides flat out.
            if (sent_count >= next_phase)
            begin
                no_idle    = ($urandom_range(0, 3) == 0);
                next_phase = next_phase + PHASE_ITEMS;
            end
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                dbl  = 1'($urandom_range(0, 1));
                addr = aligned_addr(dbl);
                send_amo(MODE_LR, dbl, addr, rand_word(), pick_value());
                steps = $urandom_range(0, 3);
                repeat (steps)
                begin
                    op_dbl = 1'($urandom_range(0, 1));
                    send_amo(mode_t'($urandom_range(MODE_XOR, MODE_MAXU)), op_dbl,
                             $urandom_range(0, 1) ? addr : aligned_addr(op_dbl),
                             pick_value(), pick_value());
                end
                // Most SCs hit the reservation; some miss by one bit, others by more.
                case ($urandom_range(0, 7))
                    0:       sc_addr = addr ^ (word_t'(1) << $urandom_range(2, 63));
                    1:       sc_addr = aligned_addr(dbl);
                    default: sc_addr = addr;
                endcase
                send_amo(MODE_SC, dbl, sc_addr, pick_value(), pick_value());
                lrsc_sequences++;
            end
            else if (kind < 8)
            begin
                dbl = 1'($urandom_range(0, 1));
                send_amo(legal_mode(), dbl, aligned_addr(dbl), pick_value(), pick_value());
            end
            else if (kind == 8)
            begin
                dbl  = 1'($urandom_range(0, 1));
                addr = rand_word();
                if (dbl)
                    addr[2:0] = 3'($urandom_range(1, 7));
                else
                    addr[1:0] = 2'($urandom_range(1, 3));
                send_amo(legal_mode(), dbl, addr, pick_value(), pick_value());
            end
            else
            begin
                send_amo(mode_t'($urandom_range(0, (1 << MODE_W) - 1)),
                         1'($urandom_range(0, 1)),
                         rand_word(), rand_word(), rand_word());
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain the outstanding results, then watch a little longer for strays.
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d operations: %0d directed, %0d reserve/conditional sequences.",
                 sent_count, directed_items, lrsc_sequences);
        $display("Compared %0d result beats, %0d conditional stores taken, %0d mismatches.",
                 checked, sc_success, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
